[hdl/hfr_pkg.sv]
package hfr_pkg;

   // Control characters of the link.
   localparam logic [7:0] CH_NUL  = 8'h00;
   localparam logic [7:0] CH_STX  = 8'h02;
   localparam logic [7:0] CH_ETX  = 8'h03;
   localparam logic [7:0] CH_ACK  = 8'h06;
   localparam logic [7:0] CH_NAK  = 8'h15;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;
   localparam logic [7:0] CH_A_UP = 8'h41;
   localparam logic [7:0] CH_F_UP = 8'h46;

   // Input operation codes.
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Result kinds.
   localparam logic KIND_REPLY = 1'b0;
   localparam logic KIND_MSG   = 1'b1;

   // A reply carries ACK plus at most fifteen message bytes.
   localparam int MAX_RESULTS = 16;
   localparam int MSG_W       = 4;
   localparam int CMD_DEPTH   = 2;

   typedef struct packed {
      logic       opcode;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] data;
      logic       last;
   } rsp_type;

   // Work handed from the front to the back: a NAK, or an ACK with message bytes.
   typedef struct packed {
      logic             nak;
      logic [MSG_W-1:0] msg_count;
   } cmd_type;

   typedef enum logic {
      BK_IDLE,
      BK_MSG
   } back_state_type;

   // Upper-case ASCII character of one hex digit.
   function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
      logic [7:0] wide;
      wide = {4'h0, nib};
      if (nib < 4'd10) begin
         return CH_ZERO + wide;
      end else begin
         return CH_A_UP + wide - 8'd10;
      end
   endfunction

endpackage

[hdl/hfr_ram.sv]
module hfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/hfr_cmd_fifo.sv]
module hfr_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  hfr_pkg::cmd_type  push_data,
   input  logic              pop,
   output hfr_pkg::cmd_type  pop_data,
   output logic              empty,
   output logic              full
);

   localparam int PW = $clog2(hfr_pkg::CMD_DEPTH);

   hfr_pkg::cmd_type entry_ff [hfr_pkg::CMD_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == (PW+1)'(hfr_pkg::CMD_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(hfr_pkg::CMD_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(hfr_pkg::CMD_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hdl/hfr_front.sv]
module hfr_front #(
   parameter int MAX_CHARS = 32,
   parameter int AW        = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_accept,
   input  hfr_pkg::req_type  req_payload,
   input  logic [15:0]       timeout_ms,
   output logic              cmd_push,
   output hfr_pkg::cmd_type  cmd_data,
   output logic              ram_wr_en,
   output logic [AW-1:0]     ram_wr_addr,
   output logic [7:0]        ram_wr_data,
   output logic              frame_open
);

   localparam int CW = $clog2(MAX_CHARS + 1);

   logic          open_ff, open_in;
   logic [CW-1:0] count_ff, count_in;
   logic [15:0]   quiet_ff, quiet_in;
   logic [3:0]    hi_ff, hi_in;
   logic [7:0]    sum_ff, sum_in;
   logic [7:0]    last_ff, last_in;

   logic          is_hex;
   logic [3:0]    nib;
   logic [7:0]    rx;
   logic [15:0]   quiet_inc;
   logic [CW-1:0] n_bytes;
   logic [CW-1:0] n_msg;
   logic          frame_good;
   logic          store_full;

   assign rx = req_payload.rx_byte;

   // Classify the received character as an upper-case hex digit.
   always_comb begin
      is_hex = 1'b0;
      nib    = rx[3:0];
      if (rx >= hfr_pkg::CH_ZERO && rx <= hfr_pkg::CH_NINE) begin
         is_hex = 1'b1;
      end else if (rx >= hfr_pkg::CH_A_UP && rx <= hfr_pkg::CH_F_UP) begin
         is_hex = 1'b1;
         nib    = rx[3:0] + 4'd9;
      end
   end

   // The checksum over all bytes but the newest is kept as the frame grows.
   assign quiet_inc  = (quiet_ff == 16'hFFFF) ? quiet_ff : quiet_ff + 16'd1;
   assign n_bytes    = {1'b0, count_ff[CW-1:1]};
   assign n_msg      = n_bytes - 1'b1;
   assign store_full = (count_ff >= CW'(MAX_CHARS));
   assign frame_good = open_ff && !count_ff[0] && (n_bytes >= CW'(2)) && (sum_ff == last_ff);

   // Per-item decision and state update.
   always_comb begin
      open_in     = open_ff;
      count_in    = count_ff;
      quiet_in    = quiet_ff;
      hi_in       = hi_ff;
      sum_in      = sum_ff;
      last_in     = last_ff;
      cmd_push    = 1'b0;
      cmd_data    = '0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = AW'(count_ff[CW-1:1]);
      ram_wr_data = {hi_ff, nib};
      if (req_accept) begin
         case (req_payload.opcode)
            hfr_pkg::OP_TICK: begin
               quiet_in = quiet_inc;
               if (open_ff && quiet_inc > timeout_ms) begin
                  open_in      = 1'b0;
                  count_in     = '0;
                  cmd_push     = 1'b1;
                  cmd_data.nak = 1'b1;
               end
            end
            hfr_pkg::OP_BYTE: begin
               quiet_in = '0;
               case (rx)
                  hfr_pkg::CH_NUL, hfr_pkg::CH_NAK: begin
                  end
                  hfr_pkg::CH_STX: begin
                     open_in  = 1'b1;
                     count_in = '0;
                     sum_in   = '0;
                  end
                  hfr_pkg::CH_ETX: begin
                     open_in  = 1'b0;
                     count_in = '0;
                     cmd_push = 1'b1;
                     cmd_data.nak = !frame_good;
                     if (n_msg > CW'(hfr_pkg::MAX_RESULTS - 1) && CW > hfr_pkg::MSG_W) begin
                        cmd_data.msg_count = hfr_pkg::MSG_W'(hfr_pkg::MAX_RESULTS - 1);
                     end else begin
                        cmd_data.msg_count = hfr_pkg::MSG_W'(n_msg);
                     end
                  end
                  default: begin
                     if (open_ff) begin
                        if (store_full || !is_hex) begin
                           open_in  = 1'b0;
                           count_in = '0;
                        end else begin
                           count_in = count_ff + 1'b1;
                           if (!count_ff[0]) begin
                              hi_in = nib;
                           end else begin
                              ram_wr_en = 1'b1;
                              last_in   = {hi_ff, nib};
                              if (count_ff[CW-1:1] != '0) begin
                                 sum_in = sum_ff + hfr_pkg::hex_ascii(last_ff[7:4])
                                        + hfr_pkg::hex_ascii(last_ff[3:0]);
                              end
                           end
                        end
                     end
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff  <= 1'b0;
         count_ff <= '0;
         quiet_ff <= '0;
      end else begin
         open_ff  <= open_in;
         count_ff <= count_in;
         quiet_ff <= quiet_in;
      end
   end

   // Frame payload registers need no reset.
   always_ff @(posedge clock) begin
      hi_ff   <= hi_in;
      sum_ff  <= sum_in;
      last_ff <= last_in;
   end

   assign frame_open = open_ff;

endmodule

[hdl/hfr_back.sv]
module hfr_back #(
   parameter int AW = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_empty,
   input  hfr_pkg::cmd_type  cmd_data,
   output logic              cmd_pop,
   output logic              ram_rd_en,
   output logic [AW-1:0]     ram_rd_addr,
   input  logic [7:0]        ram_rd_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hfr_pkg::rsp_type  rsp_payload,
   output logic              busy
);

   hfr_pkg::back_state_type         state_ff, state_in;
   logic                            out_valid_ff, out_valid_in;
   hfr_pkg::rsp_type                out_ff, out_in;
   logic [hfr_pkg::MSG_W-1:0]       idx_ff, idx_in;
   logic [hfr_pkg::MSG_W-1:0]       cnt_ff, cnt_in;
   logic                            out_free;
   logic                            msg_last;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign msg_last = (idx_ff + 1'b1 == cnt_ff);

   // Reply sequencer: one result per free cycle into output register.
   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_in       = out_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      cmd_pop      = 1'b0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = AW'(idx_ff);
      case (state_ff)
         hfr_pkg::BK_IDLE: begin
            if (!cmd_empty && out_free) begin
               cmd_pop      = 1'b1;
               out_valid_in = 1'b1;
               out_in.kind  = hfr_pkg::KIND_REPLY;
               if (cmd_data.nak) begin
                  out_in.data = hfr_pkg::CH_NAK;
                  out_in.last = 1'b1;
               end else begin
                  out_in.data = hfr_pkg::CH_ACK;
                  out_in.last = (cmd_data.msg_count == '0);
                  if (cmd_data.msg_count != '0) begin
                     idx_in      = '0;
                     cnt_in      = cmd_data.msg_count;
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = '0;
                     state_in    = hfr_pkg::BK_MSG;
                  end
               end
            end
         end
         hfr_pkg::BK_MSG: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in.kind  = hfr_pkg::KIND_MSG;
               out_in.data  = ram_rd_data;
               out_in.last  = msg_last;
               if (msg_last) begin
                  state_in = hfr_pkg::BK_IDLE;
               end else begin
                  idx_in      = idx_ff + 1'b1;
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = AW'(idx_ff + 1'b1);
               end
            end
         end
         default: begin
            state_in = hfr_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hfr_pkg::BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload and walk registers need no reset.
   always_ff @(posedge clock) begin
      out_ff <= out_in;
      idx_ff <= idx_in;
      cnt_ff <= cnt_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;
   assign busy        = (state_ff == hfr_pkg::BK_MSG);

endmodule

[hdl/hex_frame_receiver_ack_nak.sv]
// Channel   Direction  Handshake           Payload
// req_      in         req_valid/req_stall  hfr_pkg::req_type (opcode, rx_byte)
// rsp_      out        rsp_valid/rsp_stall  hfr_pkg::rsp_type (kind, data, last)
// csr_      in         csr_wr_en            csr_wr_data: timeout in milliseconds
//
// The front takes one byte or tick per cycle while req_stall is low and keeps the
// frame checksum as it goes. A frame end yields one reply in the back: a NAK alone,
// or an ACK and m message bytes, with one byte store read per message byte.
// While a frame is open every item stalls as long as the back still reads the byte
// store; any item stalls while the two-entry command queue is full. Reset is
// synchronous and active high.
module hex_frame_receiver_ack_nak #(
   parameter int MAX_CHARS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  hfr_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hfr_pkg::rsp_type  rsp_payload,
   input  logic              csr_wr_en,
   input  logic [15:0]       csr_wr_data
);

   localparam int STORE_DEPTH = (MAX_CHARS + 1) / 2;
   localparam int AW          = $clog2(STORE_DEPTH);

   logic             timeout_ff;
   logic [15:0]      timeout_ms_ff;
   logic             req_accept;
   logic             cmd_push, cmd_pop, cmd_empty, cmd_full;
   hfr_pkg::cmd_type cmd_in_data, cmd_out_data;
   logic             ram_wr_en, ram_rd_en;
   logic [AW-1:0]    ram_wr_addr, ram_rd_addr;
   logic [7:0]       ram_wr_data, ram_rd_data;
   logic             frame_open;
   logic             back_busy;
   logic             store_busy;

   // Timeout register.
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ms_ff <= 16'd100;
         timeout_ff    <= 1'b0;
      end else begin
         timeout_ff <= csr_wr_en;
         if (csr_wr_en) begin
            timeout_ms_ff <= csr_wr_data;
         end
      end
   end

   // The store is in use from a queued command until its last byte has been read.
   assign store_busy = !cmd_empty || back_busy;
   assign req_stall  = cmd_full || (store_busy && frame_open);
   assign req_accept = req_valid && !req_stall;

   hfr_front #(
      .MAX_CHARS (MAX_CHARS),
      .AW        (AW)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_accept  (req_accept),
      .req_payload (req_payload),
      .timeout_ms  (timeout_ms_ff),
      .cmd_push    (cmd_push),
      .cmd_data    (cmd_in_data),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .frame_open  (frame_open)
   );

   hfr_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in_data),
      .pop       (cmd_pop),
      .pop_data  (cmd_out_data),
      .empty     (cmd_empty),
      .full      (cmd_full)
   );

   hfr_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   hfr_back #(
      .AW (AW)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_empty   (cmd_empty),
      .cmd_data    (cmd_out_data),
      .cmd_pop     (cmd_pop),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .busy        (back_busy)
   );

   // The front never writes the store while the back may still read it.
   a_store_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && store_busy))
      else $error("byte store written while a reply is being read");

   // A command is never offered to a full queue without a pop in the same cycle.
   a_cmd_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> (!cmd_full || cmd_pop))
      else $error("command queue overflow");

   // A written timeout is in force from the next cycle.
   a_timeout_written: assert property (@(posedge clock) disable iff (reset)
      timeout_ff |-> (timeout_ms_ff == $past(csr_wr_data)))
      else $error("timeout register did not take the written value");

endmodule
